// ===== hdl/yhd_pkg.sv =====
`timescale 1ns / 1ps

package yhd_pkg;

  localparam int MAX_CLASSES_DEF  = 128;
  localparam int ANCHOR_COUNT_DEF = 3;
  localparam int MAX_GRID_DEF     = 128;

  localparam int SIG_ROM_DEPTH = 1024;
  localparam int SIG_IDX_W     = 10;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_THR = 3'd0,
    REG_GRID      = 3'd1,
    REG_IMG_W     = 3'd2,
    REG_IMG_H     = 3'd3,
    REG_CLASSES   = 3'd4,
    REG_ANCHOR0   = 3'd5,
    REG_ANCHOR1   = 3'd6,
    REG_ANCHOR2   = 3'd7
  } cfg_reg_e;

  typedef logic [15:0] sig_rom_t [SIG_ROM_DEPTH];

  // Unsigned 64-bit quotient by shift and subtract, for table building
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid table in Q0.16, built at elaboration from a Q2.62 series for
  // exp(-1/64) raised to successive powers.
  function automatic sig_rom_t build_sig_rom();
    logic [63:0]  c;
    logic [63:0]  term;
    logic [63:0]  p;
    logic [63:0]  pw [513];
    logic [127:0] prod;
    logic [63:0]  p46;
    logic [63:0]  den;
    logic [63:0]  num;
    int           k;
    sig_rom_t     rom;
    c    = 64'd1 << 62;
    term = 64'd1 << 62;
    p    = 64'd1 << 62;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64(term, 64'(64 * n));
      if (n[0] == 1'b1) c = c - term;
      else c = c + term;
    end
    pw[0] = p;
    for (int n = 1; n <= 512; n++) begin
      prod  = {64'd0, p} * {64'd0, c};
      p     = prod[125:62];
      pw[n] = p;
    end
    for (int i = 0; i < SIG_ROM_DEPTH; i++) begin
      k   = i - 512;
      p46 = pw[(k >= 0) ? k : -k] >> 16;
      den = (64'd1 << 46) + p46;
      num = (k >= 0) ? (64'd1 << 46) : p46;
      rom[i] = 16'(udiv64(64'd131070 * num + den, den << 1));
    end
    return rom;
  endfunction

endpackage

// ===== hdl/yhd_sig_rom.sv =====
`timescale 1ns / 1ps

module yhd_sig_rom (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [yhd_pkg::SIG_IDX_W-1:0] addr_i,
  output logic [15:0]                   data_o
);
  import yhd_pkg::*;

  localparam sig_rom_t ROM = build_sig_rom();

  logic [15:0] data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// ===== hdl/yhd_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module yhd_div #(
  parameter int NW  = 38,
  parameter int DVW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [NW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic           done_o,
  output logic [NW-1:0]  quot_o,
  output logic           rem_nz_o
);
  import yhd_pkg::*;

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DVW-1:0]  rem_q;
  logic [DVW-1:0]  dvs_q;
  logic [DVW:0]    trial;
  logic [DVW:0]    diff;
  logic            take;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    diff  = trial - {1'b0, dvs_q};
    take  = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], take};
      rem_q <= take ? diff[DVW-1:0] : trial[DVW-1:0];
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

// ===== hdl/yolo_head_decode.sv =====
`timescale 1ns / 1ps

// Detection head decoder for one head layer.
// Input channel: one signed Q8.8 logit per beat (in_valid_i/in_ready_o),
// map_start_i marks the first element of a layer map. Elements run per cell
// as x, y, w, h, objectness, then the class logits.
// Output channel: at most one beat per cell, on its last class logit:
// corner box and size in Q12.4, score in Q0.16 and the best class index.
// Configuration channel: cfg_valid_i/cfg_ready_o with a register index and
// 32-bit data; always ready, write only while the block is idle.
// Sequencing: an element that does not close a cell is accepted, then the
// registered sigmoid ROM read is applied. The closing element then forms
// the score and drops the cell or runs both axes through the single shared
// multiplier and the bit-serial divider, used once per axis, which has
// NW = clog2(MAX_GRID)+31 quotient bits. in_ready_o is high only while
// the sequencer idles.
// Reset clears the configuration to its defaults and all cell state.
// A result waits in the output register while the next cell is taken in;
// the sequencer only holds when a new result is ready and the receiver
// still stalls the previous one.
module yolo_head_decode #(
  parameter int MAX_CLASSES  = yhd_pkg::MAX_CLASSES_DEF,
  parameter int ANCHOR_COUNT = yhd_pkg::ANCHOR_COUNT_DEF,
  parameter int MAX_GRID     = yhd_pkg::MAX_GRID_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [15:0]             logit_i,
  input  logic                           map_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             box_left_o,
  output logic signed [15:0]             box_top_o,
  output logic [15:0]                    box_width_o,
  output logic [15:0]                    box_height_o,
  output logic [15:0]                    score_o,
  output logic [6:0]                     class_index_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [yhd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [yhd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import yhd_pkg::*;

  localparam int LASTW = $clog2(MAX_CLASSES + 5);
  localparam int CPW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CLW   = $clog2(MAX_CLASSES + 1);
  localparam int GW    = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int GLW   = $clog2(MAX_GRID + 1);
  localparam int AW    = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;
  localparam int C16W  = GW + 19;
  localparam int MAW   = (C16W > 33) ? C16W : 33;
  localparam int PW    = MAW + 17;
  localparam int NW    = C16W + 12;
  localparam int QW    = NW + 1;
  localparam int EDW   = QW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_APPLY, S_SCORE, S_CHECK, S_CPIX, S_DIVGO, S_DIVW,
    S_SQ, S_LEN, S_EDGE, S_EMIT, S_ADV
  } state_e;

  state_e           state_q;
  logic [15:0]      thr_q;
  logic [7:0]       grid_q;
  logic [12:0]      img_w_q;
  logic [12:0]      img_h_q;
  logic [7:0]       classes_q;
  logic [31:0]      anchor_q [3];
  logic [LASTW-1:0] elem_q;
  logic [GW-1:0]    col_q;
  logic [GW-1:0]    row_q;
  logic [AW-1:0]    anc_q;
  logic [15:0]      box_sig_q [4];
  logic [15:0]      obj_q;
  logic [15:0]      best_q;
  logic [CPW-1:0]   best_pos_q;
  logic             rej_q;
  logic             axis_q;
  logic             out_valid_q;

  logic signed [PW-1:0] prod_q;
  logic signed [QW-1:0] cq_q;
  logic                 neg_q;
  logic signed [15:0]   left_s_q;
  logic signed [15:0]   top_s_q;
  logic [15:0]          w_s_q;
  logic [15:0]          h_s_q;
  logic [15:0]          score_s_q;
  logic [6:0]           cls_s_q;
  logic signed [15:0]   left_q;
  logic signed [15:0]   top_q;
  logic [15:0]          w_q;
  logic [15:0]          h_q;
  logic [15:0]          score_q;
  logic [6:0]           cls_q;

  logic [CLW-1:0]       cc;
  logic [GLW-1:0]       g;
  logic [LASTW-1:0]     last;
  logic [LASTW-1:0]     e;
  logic [15:0]          sig;
  logic signed [13:0]   sig_k;
  logic [SIG_IDX_W-1:0] sig_idx;
  logic                 accept;
  logic                 load;
  logic [15:0]          s_pos;
  logic [15:0]          s_len;
  logic [GW-1:0]        cell_pos;
  logic [12:0]          pix;
  logic [31:0]          pair;
  logic [15:0]          anchor;
  logic [1:0]           anc2;
  logic signed [C16W-1:0] c16;
  logic signed [MAW-1:0]  mul_a;
  logic signed [16:0]     mul_b;
  logic [PW-1:0]          prod_mag;
  logic [NW-1:0]          div_quot;
  logic                   div_rem_nz;
  logic                   div_done;
  logic signed [QW-1:0]   cq_d;
  logic [29:0]            len16;
  logic signed [EDW-1:0]  edge_v;
  logic signed [EDW-1:0]  corner_sh;
  logic [15:0]            corner;
  logic [30:0]            size_sh;
  logic [15:0]            size_v;
  logic [15:0]            score_v;
  logic [CPW+6:0]         cls_ext;
  logic [GLW:0]           col_nx;
  logic [GLW:0]           row_nx;
  logic [AW:0]            anc_nx;

  // Sigmoid ROM index: clamp(logit >>> 2) to [-512, 511], offset by 512
  always_comb begin
    sig_k = logit_i[15:2];
    if (sig_k < -14'sd512) begin
      sig_idx = '0;
    end else if (sig_k > 14'sd511) begin
      sig_idx = '1;
    end else begin
      sig_idx = {~sig_k[9], sig_k[8:0]};
    end
  end

  assign accept = in_valid_i && in_ready_o;

  yhd_sig_rom u_rom (
    .clk_i   (clk_i),
    .rd_en_i (accept),
    .addr_i  (sig_idx),
    .data_o  (sig)
  );

  // Effective class count, grid and element position
  always_comb begin
    if (classes_q == 8'd0) begin
      cc = CLW'(1);
    end else if ({1'b0, classes_q} > 9'(MAX_CLASSES)) begin
      cc = CLW'(MAX_CLASSES);
    end else begin
      cc = CLW'(classes_q);
    end
    if (grid_q == 8'd0) begin
      g = GLW'(1);
    end else if ({1'b0, grid_q} > 9'(MAX_GRID)) begin
      g = GLW'(MAX_GRID);
    end else begin
      g = GLW'(grid_q);
    end
    last = LASTW'(cc) + LASTW'(4);
    e    = (elem_q > last) ? last : elem_q;
  end

  // Per-axis operand selection
  always_comb begin
    anc2 = 2'(anc_q);
    case (anc2)
      2'd1:    pair = anchor_q[1];
      2'd2:    pair = anchor_q[2];
      default: pair = anchor_q[0];
    endcase
    s_pos    = axis_q ? box_sig_q[1] : box_sig_q[0];
    s_len    = axis_q ? box_sig_q[3] : box_sig_q[2];
    cell_pos = axis_q ? row_q : col_q;
    pix      = axis_q ? img_h_q : img_w_q;
    anchor   = axis_q ? pair[31:16] : pair[15:0];
    // Center in Q.16 cells: 2*s - 0.5 + cell position
    c16 = $signed(C16W'({cell_pos, 16'd0})) + $signed(C16W'({s_pos, 1'b0}))
          - C16W'(32768);
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SCORE: begin
        mul_a = $signed(MAW'(obj_q));
        mul_b = $signed({1'b0, best_q});
      end
      S_CPIX: begin
        mul_a = MAW'(c16);
        mul_b = $signed(17'(pix));
      end
      S_SQ: begin
        mul_a = $signed(MAW'(s_len));
        mul_b = $signed({1'b0, s_len});
      end
      S_LEN: begin
        mul_a = $signed(MAW'(prod_q[31:0]));
        mul_b = $signed({1'b0, anchor});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_mag = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);

  yhd_div #(
    .NW  (NW),
    .DVW (GLW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIVGO),
    .dividend_i (prod_mag[NW-1:0]),
    .divisor_i  (g),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  // Floor division result, corner and size of one axis
  always_comb begin
    if (neg_q) begin
      cq_d = -($signed({1'b0, div_quot}) + $signed(QW'(div_rem_nz)));
    end else begin
      cq_d = $signed({1'b0, div_quot});
    end
    len16     = prod_q[47:18];
    edge_v    = (EDW'(cq_q) <<< 1) - $signed(EDW'(len16));
    corner_sh = (edge_v + EDW'(4096)) >>> 13;
    if (corner_sh > EDW'(32767)) begin
      corner = 16'h7fff;
    end else if (corner_sh < EDW'(-32768)) begin
      corner = 16'h8000;
    end else begin
      corner = corner_sh[15:0];
    end
    size_sh = ({1'b0, len16} + 31'd2048) >> 12;
    size_v  = (|size_sh[30:16]) ? 16'hffff : size_sh[15:0];
    score_v = prod_q[31:16];
    cls_ext = (CPW + 7)'(best_pos_q);
  end

  // Position counters past the closing element
  always_comb begin
    col_nx = (GLW + 1)'(col_q) + (GLW + 1)'(1);
    row_nx = (GLW + 1)'(row_q) + (GLW + 1)'(1);
    anc_nx = (AW + 1)'(anc_q) + (AW + 1)'(1);
  end

  assign load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // Sequencer, configuration and cell state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      thr_q        <= 16'd16384;
      grid_q       <= 8'd80;
      img_w_q      <= 13'd640;
      img_h_q      <= 13'd640;
      classes_q    <= 8'd80;
      anchor_q[0]  <= '0;
      anchor_q[1]  <= '0;
      anchor_q[2]  <= '0;
      elem_q       <= '0;
      col_q        <= '0;
      row_q        <= '0;
      anc_q        <= '0;
      box_sig_q[0] <= '0;
      box_sig_q[1] <= '0;
      box_sig_q[2] <= '0;
      box_sig_q[3] <= '0;
      obj_q        <= '0;
      best_q       <= '0;
      best_pos_q   <= '0;
      rej_q        <= 1'b0;
      axis_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_SCORE_THR: thr_q       <= cfg_data_i[15:0];
          REG_GRID:      grid_q      <= cfg_data_i[7:0];
          REG_IMG_W:     img_w_q     <= cfg_data_i[12:0];
          REG_IMG_H:     img_h_q     <= cfg_data_i[12:0];
          REG_CLASSES:   classes_q   <= cfg_data_i[7:0];
          REG_ANCHOR0:   anchor_q[0] <= cfg_data_i;
          REG_ANCHOR1:   anchor_q[1] <= cfg_data_i;
          REG_ANCHOR2:   anchor_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      // Raise the valid flag on a load, else drop the held result once the receiver takes it
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (map_start_i) begin
              elem_q <= '0;
              col_q  <= '0;
              row_q  <= '0;
              anc_q  <= '0;
            end
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (e < LASTW'(4)) begin
            if (e == '0) begin
              rej_q      <= 1'b0;
              best_q     <= '0;
              best_pos_q <= '0;
            end
            box_sig_q[e[1:0]] <= sig;
          end else if (e == LASTW'(4)) begin
            obj_q <= sig;
            if (sig < thr_q) rej_q <= 1'b1;
          end else if (sig > best_q) begin
            best_q     <= sig;
            best_pos_q <= CPW'(e - LASTW'(5));
          end
          if (e == last) begin
            state_q <= S_SCORE;
          end else begin
            elem_q  <= e + LASTW'(1);
            state_q <= S_IDLE;
          end
        end
        S_SCORE: state_q <= S_CHECK;
        S_CHECK: begin
          axis_q <= 1'b0;
          if (!rej_q && (score_v >= thr_q)) begin
            state_q <= S_CPIX;
          end else begin
            state_q <= S_ADV;
          end
        end
        S_CPIX:  state_q <= S_DIVGO;
        S_DIVGO: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_done) state_q <= S_SQ;
        end
        S_SQ:    state_q <= S_LEN;
        S_LEN:   state_q <= S_EDGE;
        S_EDGE: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= S_CPIX;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) state_q <= S_ADV;
        end
        S_ADV: begin
          // Advance column, then row, then anchor
          elem_q <= '0;
          if (col_nx >= (GLW + 1)'(g)) begin
            col_q <= '0;
            if (row_nx >= (GLW + 1)'(g)) begin
              row_q <= '0;
              if (anc_nx >= (AW + 1)'(ANCHOR_COUNT)) begin
                anc_q <= '0;
              end else begin
                anc_q <= anc_nx[AW-1:0];
              end
            end else begin
              row_q <= row_nx[GW-1:0];
            end
          end else begin
            col_q <= col_nx[GW-1:0];
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_SCORE, S_CPIX, S_SQ, S_LEN: prod_q <= mul_a * mul_b;
      default: ;
    endcase
    if (state_q == S_DIVGO) begin
      neg_q <= prod_q[PW-1];
    end
    if ((state_q == S_DIVW) && div_done) begin
      cq_q <= cq_d;
    end
    if (state_q == S_CHECK) begin
      score_s_q <= score_v;
      cls_s_q   <= cls_ext[6:0];
    end
    if (state_q == S_EDGE) begin
      if (!axis_q) begin
        left_s_q <= corner;
        w_s_q    <= size_v;
      end else begin
        top_s_q <= corner;
        h_s_q   <= size_v;
      end
    end
    if (load) begin
      left_q  <= left_s_q;
      top_q   <= top_s_q;
      w_q     <= w_s_q;
      h_q     <= h_s_q;
      score_q <= score_s_q;
      cls_q   <= cls_s_q;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign box_left_o    = left_q;
  assign box_top_o     = top_q;
  assign box_width_o   = w_q;
  assign box_height_o  = h_q;
  assign score_o       = score_q;
  assign class_index_o = cls_q;

endmodule

// ===== hdl/yhd_checker.sv =====
`timescale 1ns / 1ps

module yhd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] box_left_o,
  input logic signed [15:0] box_top_o,
  input logic [15:0]        box_width_o,
  input logic [15:0]        box_height_o,
  input logic [15:0]        score_o,
  input logic [6:0]         class_index_o
);
  import yhd_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(box_left_o) && $stable(box_top_o)
      && $stable(box_width_o) && $stable(box_height_o) && $stable(score_o)
      && $stable(class_index_o))
    else $error("result payload changed while stalled");

  // One element at a time: the sequencer is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on two consecutive cycles");

  // A result appears only out of the box sequence, never from idle
  a_emit_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while sequencer idle");

endmodule

bind yolo_head_decode yhd_checker u_yhd_checker (.*);

// ===== verif/tb_yolo_head_decode.sv =====
`timescale 1ns / 1ps

// Testbench for the detection head decoder.
// Stream logit beats and keep a bit-true model of the decoder next to the DUT.
// Each accepted beat advances the model; a surviving cell queues one
// detection. Each detection beat from the DUT is checked field by field
// against the oldest queued detection.
module tb_yolo_head_decode;
  import yhd_pkg::*;

  localparam int MODEL_MAX_CLASSES = 128;
  localparam int MODEL_ANCHORS     = 3;
  localparam int MODEL_MAX_GRID    = 128;
  // Longest busy stretch of the DUT after its last beat (closing cell, both
  // divider passes), with margin.
  localparam int DRAIN_CYCLES      = 150;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [15:0]        width;
    logic [15:0]        height;
    logic [15:0]        score;
    logic [6:0]         cls;
  } detection_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic signed [15:0]    logit_i;
  logic                  map_start_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic signed [15:0]    box_left_o;
  logic signed [15:0]    box_top_o;
  logic [15:0]           box_width_o;
  logic [15:0]           box_height_o;
  logic [15:0]           score_o;
  logic [6:0]            class_index_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  yolo_head_decode dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .logit_i      (logit_i),
    .map_start_i  (map_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .box_left_o   (box_left_o),
    .box_top_o    (box_top_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o),
    .score_o      (score_o),
    .class_index_o(class_index_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Model configuration, mirrors the register file.
  logic [15:0] thr_cfg;
  logic [7:0]  grid_cfg;
  logic [12:0] img_w_cfg;
  logic [12:0] img_h_cfg;
  logic [7:0]  classes_cfg;
  logic [31:0] anchor_cfg [MODEL_ANCHORS];

  // Model cell state.
  int unsigned elem_pos, col_pos, row_pos, anchor_pos;
  logic [15:0] box_sig [4];
  logic [15:0] obj_sig;
  logic [15:0] best_sig;
  int unsigned best_pos;
  bit          cell_drop;

  logic [15:0] sig_table [1024];

  detection_t  detections_q [$];
  int          mismatches;
  int          detections_seen;
  int          beats_sent;
  int          cells_closed;
  bit          calm;  // no idling on either side while set

  // Sigmoid table: exp(-1/64) as a truncated series in Q2.62, then its powers.
  function automatic void fill_sig_table();
    longint unsigned base, term, pw_val, p46, den, num;
    longint unsigned pw [513];
    logic [127:0]    prod;
    int              k;
    base = 64'd1 << 62;
    term = 64'd1 << 62;
    for (int n = 1; n <= 12; n++) begin
      term = term / longint'(64 * n);
      if (n % 2 == 1) base = base - term;
      else base = base + term;
    end
    pw_val = 64'd1 << 62;
    pw[0] = pw_val;
    for (int n = 1; n <= 512; n++) begin
      prod   = {64'd0, pw_val} * {64'd0, base};
      pw_val = prod[125:62];
      pw[n]  = pw_val;
    end
    for (int i = 0; i < 1024; i++) begin
      k   = i - 512;
      p46 = pw[(k >= 0) ? k : -k] >> 16;
      den = (64'd1 << 46) + p46;
      num = (k >= 0) ? (64'd1 << 46) : p46;
      sig_table[i] = 16'((64'd131070 * num + den) / (64'd2 * den));
    end
  endfunction

  function automatic logic [15:0] sigmoid_q16(logic [15:0] raw);
    logic signed [13:0] coarse;
    int                 k;
    coarse = raw[15:2];
    k = coarse;
    if (k < -512) k = -512;
    if (k > 511) k = 511;
    return sig_table[k + 512];
  endfunction

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // One axis: corner (signed Q12.4) and extent (unsigned Q12.4).
  function automatic void axis_extent(input logic [15:0] s_pos, input logic [15:0] s_len,
                                      input int unsigned cell_idx, input longint pixels,
                                      input longint g, input longint unsigned anchor,
                                      output logic [15:0] corner,
                                      output logic [15:0] extent);
    longint          c16, center, edge2, c12;
    longint unsigned t, len16, sz;
    c16    = 2 * longint'(s_pos) - 32768 + longint'(cell_idx) * 65536;
    center = floor_quot(c16 * pixels, g);
    t      = 2 * longint'(s_len);
    len16  = (t * t * anchor) >> 20;
    edge2  = 2 * center - longint'(len16);
    c12    = floor_quot(edge2 + 4096, 8192);
    if (c12 > 32767) c12 = 32767;
    if (c12 < -32768) c12 = -32768;
    corner = 16'(c12);
    sz     = (len16 + 2048) >> 12;
    extent = (sz > 65535) ? 16'hFFFF : 16'(sz);
  endfunction

  // Advance the model by one accepted beat; return 1 when a detection leaves.
  function automatic bit decode_beat(input logic [15:0] raw, input logic start,
                                     output detection_t det);
    int unsigned     cc, g, last, e, a;
    logic [15:0]     s;
    longint unsigned prod;
    bit              hit;
    hit = 0;
    det = '0;
    if (start) begin
      elem_pos = 0; col_pos = 0; row_pos = 0; anchor_pos = 0;
    end
    cc = classes_cfg;
    if (cc == 0) cc = 1;
    if (cc > MODEL_MAX_CLASSES) cc = MODEL_MAX_CLASSES;
    g = grid_cfg;
    if (g == 0) g = 1;
    if (g > MODEL_MAX_GRID) g = MODEL_MAX_GRID;
    last = 4 + cc;
    s = sigmoid_q16(raw);
    e = (elem_pos > last) ? last : elem_pos;

    if (e < 4) begin
      if (e == 0) begin
        cell_drop = 0;
        best_sig  = 0;
        best_pos  = 0;
      end
      box_sig[e] = s;
    end else if (e == 4) begin
      obj_sig = s;
      if (s < thr_cfg) cell_drop = 1;
    end else if (s > best_sig) begin
      best_sig = s;
      best_pos = e - 5;
    end

    if (e == last) begin
      prod = (longint'(obj_sig) * longint'(best_sig)) >> 16;
      if (!cell_drop && prod >= thr_cfg) begin
        a = (anchor_pos < 3) ? anchor_pos : 0;
        axis_extent(box_sig[0], box_sig[2], col_pos, img_w_cfg, g,
                    anchor_cfg[a][15:0], det.left, det.width);
        axis_extent(box_sig[1], box_sig[3], row_pos, img_h_cfg, g,
                    anchor_cfg[a][31:16], det.top, det.height);
        det.score = 16'(prod);
        det.cls   = 7'(best_pos);
        hit = 1;
      end
      elem_pos = 0;
      col_pos++;
      if (col_pos >= g) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= g) begin
          row_pos = 0;
          anchor_pos++;
          if (anchor_pos >= MODEL_ANCHORS) anchor_pos = 0;
        end
      end
    end else begin
      elem_pos = e + 1;
    end
    return hit;
  endfunction

  // Send one logit beat; idle first now and then.
  task automatic send_logit(input logic [15:0] raw, input logic start);
    detection_t det;
    if (!calm && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    logit_i     <= raw;
    map_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (decode_beat(raw, start, det)) detections_q = {detections_q, det};
  endtask

  // Hold the stream until every detection has arrived, then wait DRAIN_CYCLES for the DUT to idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (detections_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; the caller lowers cfg_valid_i after a burst.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SCORE_THR: thr_cfg        = data[15:0];
      REG_GRID:      grid_cfg       = data[7:0];
      REG_IMG_W:     img_w_cfg      = data[12:0];
      REG_IMG_H:     img_h_cfg      = data[12:0];
      REG_CLASSES:   classes_cfg    = data[7:0];
      REG_ANCHOR0:   anchor_cfg[0]  = data;
      REG_ANCHOR1:   anchor_cfg[1]  = data;
      REG_ANCHOR2:   anchor_cfg[2]  = data;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] thr, input logic [7:0] grid,
                           input logic [12:0] iw, input logic [12:0] ih,
                           input logic [7:0] cc, input logic [31:0] a0,
                           input logic [31:0] a1, input logic [31:0] a2);
    write_reg(REG_SCORE_THR, {16'd0, thr});
    write_reg(REG_GRID, {24'd0, grid});
    write_reg(REG_IMG_W, {19'd0, iw});
    write_reg(REG_IMG_H, {19'd0, ih});
    write_reg(REG_CLASSES, {24'd0, cc});
    write_reg(REG_ANCHOR0, a0);
    write_reg(REG_ANCHOR1, a1);
    write_reg(REG_ANCHOR2, a2);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_cell(input logic [15:0] vals [], input logic start);
    foreach (vals[i]) send_logit(vals[i], start && i == 0);
  endtask

  // Extremes of the logit range, a pass-all threshold and a reject-all one.
  task automatic test_extremes();
    logic [15:0] elems [];
    write_all(16'd0, 8'd2, 13'd4096, 13'd1, 8'd1, 32'hFFFF_FFFF, 32'h0, 32'h0010_0010);
    elems = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF};
    send_cell(elems, 1'b1);
    elems = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFC, 16'h8000, 16'h0000};
    send_cell(elems, 1'b0);
    drain();
    write_reg(REG_SCORE_THR, 32'h0000_FFFF);
    cfg_valid_i <= 1'b0;
    elems = '{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h7FFF, 16'h7FFF};
    send_cell(elems, 1'b0);
    drain();
  endtask

  // Shrink the class count while a cell is open; the next beat closes it.
  task automatic test_mid_cell_config();
    logic [15:0] elems [];
    write_all(16'd0, 8'd0, 13'd0, 13'd0, 8'd3, 32'h0040_0020, 32'h0, 32'h0);
    elems = '{16'h0400, 16'hFC00, 16'h0200, 16'h0100, 16'h0800};
    send_cell(elems, 1'b1);
    drain();
    write_reg(REG_CLASSES, 32'd0);
    cfg_valid_i <= 1'b0;
    send_logit(16'h0300, 1'b0);
    drain();
  endtask

  function automatic logic [15:0] pick_logit(bit bias_up);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 255));
      3, 4, 5: return 16'($urandom);
      default: return bias_up ? 16'($urandom_range(256, 32767)) : 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_anchor();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095))};
      default: return $urandom;
    endcase
  endfunction

  // Random phases, each with its own register setting. Most cells are well
  // formed; a few carry a stray map start or get cut short.
  task automatic test_random_maps();
    logic [15:0] thr;
    logic [7:0]  grid, cc;
    logic [12:0] iw, ih;
    int          cc_eff, n_cells, len, phase, start_beats;
    start_beats = beats_sent;
    phase = 0;
    while ((beats_sent - start_beats < 600) && phase < 60) begin
      case ($urandom_range(0, 4))
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = 16'($urandom);
        default: thr = 16'($urandom_range(0, 24000));
      endcase
      case ($urandom_range(0, 6))
        0: grid = 8'd0;
        1: grid = 8'd1;
        2: grid = 8'd128;
        3: grid = 8'd255;
        default: grid = 8'($urandom_range(2, 5));
      endcase
      case ($urandom_range(0, 5))
        0: iw = 13'd0;
        1: iw = 13'd4096;
        2: iw = 13'h1FFF;
        default: iw = 13'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 5))
        0: ih = 13'd0;
        1: ih = 13'd1;
        2: ih = 13'h1FFF;
        default: ih = 13'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 11))
        0: cc = 8'd128;
        1: cc = 8'd255;
        2: cc = 8'd0;
        default: cc = 8'($urandom_range(1, 6));
      endcase
      // Keep the wide class setting rare: one cell of up to 133 beats.
      if (cc >= 128 && $urandom_range(0, 2) != 0) cc = 8'($urandom_range(1, 6));
      write_all(thr, grid, iw, ih, cc, pick_anchor(), pick_anchor(), pick_anchor());
      cc_eff  = (cc == 0) ? 1 : ((cc > 128) ? 128 : cc);
      n_cells = 60 / (cc_eff + 5);
      if (n_cells < 1) n_cells = 1;
      calm = (phase == 2);
      for (int c = 0; c < n_cells; c++) begin
        len = cc_eff + 5;
        if ($urandom_range(0, 19) == 0) len = $urandom_range(1, len);
        for (int i = 0; i < len; i++) begin
          send_logit(pick_logit(i == 4 || i > 4),
                     (c == 0 && i == 0) || ($urandom_range(0, 59) == 0));
        end
      end
      calm = 1'b0;
      drain();
      phase++;
    end
  endtask

  // Receiver: stall at random unless in a calm stretch.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 13);
  end

  // Check each detection beat against the oldest queued one.
  always @(posedge clk_i) begin : check_detection
    detection_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{box_left_o, box_top_o, box_width_o, box_height_o, score_o, class_index_o};
      detections_seen++;
      if (detections_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected detection: %p", got);
      end else begin
        want = detections_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("detection mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Limit: generous fixed time.
  initial begin
    #20_000_000;
    $display("tb_yolo_head_decode: FAIL");
    $finish;
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    logit_i     = '0;
    map_start_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    calm        = 1'b0;
    mismatches  = 0;
    detections_seen = 0;
    beats_sent  = 0;
    fill_sig_table();
    // Reset values of the model.
    thr_cfg = 16'd16384; grid_cfg = 8'd80; img_w_cfg = 13'd640; img_h_cfg = 13'd640;
    classes_cfg = 8'd80;
    foreach (anchor_cfg[i]) anchor_cfg[i] = '0;
    elem_pos = 0; col_pos = 0; row_pos = 0; anchor_pos = 0;
    foreach (box_sig[i]) box_sig[i] = '0;
    obj_sig = '0; best_sig = '0; best_pos = 0; cell_drop = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_mid_cell_config();
    test_random_maps();
    drain();

    $display("covered %0d logit beats and %0d detections over many register settings",
             beats_sent, detections_seen);
    $display("mismatches: %0d, detections left over: %0d", mismatches, detections_q.size());
    if (mismatches == 0 && detections_q.size() == 0) begin
      $display("tb_yolo_head_decode: PASS");
    end else begin
      $display("tb_yolo_head_decode: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/yhd_pkg.sv
hdl/yhd_sig_rom.sv
hdl/yhd_div.sv
hdl/yolo_head_decode.sv
hdl/yhd_checker.sv
verif/tb_yolo_head_decode.sv
